// File: src/utf8d_pkg.sv
// utf8 decoder shared types and constants
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned UNIT_W   = 16;
   localparam int unsigned REM_W    = 3;
   localparam int unsigned PAYLOAD_W = 6;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK = 6'd63;

   // decoder state carried from byte to byte
   typedef struct packed {
      logic [REM_W-1:0]  bytes_remaining;
      logic [UNIT_W-1:0] value_accumulator;
   } state_type;

   // one result beat
   typedef struct packed {
      logic              valid;
      logic [UNIT_W-1:0] code_unit;
      logic              incomplete;
      logic              end_of_text;
   } result_type;

endpackage

`default_nettype wire

// File: src/utf8d_step.sv
// per-byte decode: next state and optional result from one byte
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step
   import utf8d_pkg::*;
(
   input  wire logic [BYTE_W-1:0] byte_in,
   input  wire logic              last_byte,
   input  wire state_type         state_cur,
   output state_type              state_nxt,
   output result_type             result
);

   logic [REM_W-1:0]  lead_len;
   logic [BYTE_W-1:0] lead_mask;
   logic [UNIT_W-1:0] acc_shift;
   logic [REM_W-1:0]  rem_dec;
   logic              done;
   logic [UNIT_W-1:0] value;
   state_type         upd;

   // length is 2 plus the run of ones from bit 5 down, capped at 6
   always_comb begin
      priority if (!byte_in[5]) begin
         lead_len = 3'd2;
      end else if (!byte_in[4]) begin
         lead_len = 3'd3;
      end else if (!byte_in[3]) begin
         lead_len = 3'd4;
      end else if (!byte_in[2]) begin
         lead_len = 3'd5;
      end else begin
         lead_len = 3'd6;
      end
   end

   // keep the low (7 - length) bits of the lead byte
   assign lead_mask = (BYTE_W'(1) << (3'd7 - lead_len)) - BYTE_W'(1);
   assign acc_shift = {state_cur.value_accumulator[UNIT_W-PAYLOAD_W-1:0],
                       byte_in[PAYLOAD_W-1:0] & PAYLOAD_MASK};
   assign rem_dec   = state_cur.bytes_remaining - 3'd1;

   always_comb begin
      done  = 1'b0;
      value = '0;
      upd   = state_cur;
      if (state_cur.bytes_remaining == '0) begin
         if (!byte_in[7]) begin
            value = {{(UNIT_W-BYTE_W){1'b0}}, byte_in};
            done  = 1'b1;
         end else begin
            upd.value_accumulator = {{(UNIT_W-BYTE_W){1'b0}}, byte_in & lead_mask};
            upd.bytes_remaining   = lead_len - 3'd1;
         end
      end else begin
         upd.value_accumulator = acc_shift;
         upd.bytes_remaining   = rem_dec;
         if (rem_dec == '0) begin
            value                 = acc_shift;
            done                  = 1'b1;
            upd.value_accumulator = '0;
         end
      end

      result.valid       = done | last_byte;
      result.code_unit   = done ? value : upd.value_accumulator;
      result.incomplete  = !done;
      result.end_of_text = last_byte;

      // final byte returns the decoder to its reset state
      if (last_byte) begin
         state_nxt = '0;
      end else begin
         state_nxt = upd;
      end
   end

endmodule

`default_nettype wire

// File: src/utf8_code_point_decoder_top.sv
// utf8 code point decoder top level: input register, decode, result register
// a byte passes from the input register through the decode into the result register once that is free or draining
// throughput: one byte per cycle while the result register is free or draining, set by the single-pass decode
// bytes that only open or extend a sequence give no result beat, unless they are the last byte of the text
// reset: synchronous, active high; clears valids and the decoder state
`timescale 1ns / 1ps
`default_nettype none

module utf8_code_point_decoder_top
   import utf8d_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] byte_in
   input  wire logic              req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,   // [15:0] code_unit
   output logic                   rsp_tuser,   // [0] incomplete
   output logic                   rsp_tlast    // end_of_text
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   state_type         state_ff, state_in;
   result_type        rsp_ff, rsp_in;
   result_type        step_res;
   logic              advance;

   // result register free or draining this cycle
   assign advance    = !rsp_ff.valid || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   utf8d_step u_step (
      .byte_in   (in_byte_ff),
      .last_byte (in_last_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      rsp_in      = rsp_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_in.valid = 1'b0;
         if (in_valid_ff) begin
            rsp_in = step_res;
         end
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_ff.valid <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_ff.valid <= rsp_in.valid;
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
      // payload registers
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_ff.code_unit   <= rsp_in.code_unit;
      rsp_ff.incomplete  <= rsp_in.incomplete;
      rsp_ff.end_of_text <= rsp_in.end_of_text;
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tdata  = rsp_ff.code_unit;
   assign rsp_tuser  = rsp_ff.incomplete;
   assign rsp_tlast  = rsp_ff.end_of_text;

endmodule

`default_nettype wire

// File: sim/tb_utf8_code_point_decoder_top.sv
// self-checking testbench for the utf8 code point decoder top level
`timescale 1ns / 1ps

module tb_utf8_code_point_decoder_top;
   import utf8d_pkg::*;

   localparam int unsigned RANDOM_BYTES = 800;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned HOLD_STEP    = 300;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } text_byte_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              incomplete;
      logic              end_of_text;
   } code_unit_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = '0;   // [7:0] byte_in
   logic              req_tlast   = 1'b0; // last_byte
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [15:0]       rsp_tdata;          // [15:0] code_unit
   logic              rsp_tuser;          // [0] incomplete
   logic              rsp_tlast;          // end_of_text

   text_byte_type     pending_bytes[$];
   code_unit_type     expected_units[$];

   // decoder state mirrored on the prediction side
   logic [REM_W-1:0]  units_owed    = '0;
   logic [UNIT_W-1:0] partial_value = '0;

   int unsigned       bytes_accepted = 0;
   logic              burst_mode     = 1'b0;
   int unsigned       mismatches     = 0;
   int unsigned       units_checked  = 0;
   int unsigned       partial_units  = 0;
   int unsigned       input_stalls   = 0;
   int unsigned       holds_done     = 0;

   utf8_code_point_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // no gap in burst mode; otherwise mostly none, sometimes a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_byte(input logic [7:0] data, input logic last);
      pending_bytes.push_back({data, last});
   endtask

   // works out the code unit, if any, that one accepted byte gives
   task automatic decode_byte(input logic [7:0] data, input logic last);
      code_unit_type unit;
      logic          emit;
      int unsigned   seq_len;
      int            bit_pos;
      logic [7:0]    lead_mask;
      unit = '0;
      emit = 1'b0;
      if (units_owed == 0) begin
         if (!data[7]) begin
            unit.code_unit = {8'h00, data};
            emit = 1'b1;
         end else begin
            seq_len = 2;
            bit_pos = 5;
            while (seq_len < 6 && data[bit_pos]) begin
               seq_len++;
               bit_pos--;
            end
            lead_mask     = (8'd1 << (7 - seq_len)) - 8'd1;
            partial_value = {8'h00, data & lead_mask};
            units_owed    = REM_W'(seq_len - 1);
         end
      end else begin
         // continuation bytes are taken as they come, whatever they look like
         partial_value = {partial_value[UNIT_W-PAYLOAD_W-1:0], data[5:0] & PAYLOAD_MASK};
         units_owed    = units_owed - 1'b1;
         if (units_owed == 0) begin
            unit.code_unit = partial_value;
            emit           = 1'b1;
            partial_value  = '0;
         end
      end
      if (emit) begin
         unit.end_of_text = last;
      end else if (last) begin
         // text cut short: flush the partial value unshifted
         unit.code_unit   = partial_value;
         unit.incomplete  = 1'b1;
         unit.end_of_text = 1'b1;
         emit             = 1'b1;
      end
      if (last) begin
         units_owed    = '0;
         partial_value = '0;
      end
      if (emit) expected_units.push_back(unit);
   endtask

   // sender
   always @(posedge clock) begin : sender
      text_byte_type item;
      int unsigned   send_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_accepted <= bytes_accepted + 1;
            if ($urandom_range(0, 39) == 0) burst_mode <= !burst_mode;
         end
         if (req_tvalid && !req_tready) begin
            input_stalls++;
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            item = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data;
            req_tlast  <= item.last;
            send_gap   = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off after each HOLD_STEP bytes, at most twice, to back the block up
   always @(posedge clock) begin : receiver
      int unsigned hold_left;
      int unsigned stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done < 2 && bytes_accepted >= (holds_done + 1) * HOLD_STEP) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      code_unit_type wanted;
      code_unit_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tdata, rsp_tuser, rsp_tlast};
         if (expected_units.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected beat: code_unit %h incomplete %b end_of_text %b",
                        seen.code_unit, seen.incomplete, seen.end_of_text);
            mismatches++;
         end else begin
            wanted = expected_units.pop_front();
            units_checked++;
            if (seen.incomplete) partial_units++;
            if (seen !== wanted) begin
               if (mismatches < MAX_REPORTS)
                  $display("mismatch on unit %0d: expected %h/%b/%b got %h/%b/%b",
                           units_checked, wanted.code_unit, wanted.incomplete,
                           wanted.end_of_text, seen.code_unit, seen.incomplete,
                           seen.end_of_text);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned random_bytes;
      int unsigned n_chars;
      int unsigned roll;
      int unsigned seq_len;
      int unsigned emit_count;
      logic        truncate;
      logic        final_char;
      logic [7:0]  seq [6];

      // directed: ascii extremes, lengths two to four, capped lead, stray lead, cut-off text
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hC2, 1'b0);
      queue_byte(8'hA9, 1'b0);
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h82, 1'b0);
      queue_byte(8'hAC, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'h9F, 1'b0);
      queue_byte(8'h98, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hBF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hC0, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h80, 1'b0);   // stray continuation taken as a lead
      queue_byte(8'h3F, 1'b0);   // ascii-looking continuation
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h82, 1'b1);   // text ends mid-sequence
      queue_byte(8'hF4, 1'b1);   // text is a lone lead byte
      queue_byte(8'h41, 1'b1);
      queue_byte(8'hC2, 1'b0);
      queue_byte(8'hA9, 1'b1);

      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         n_chars  = $urandom_range(1, 16);
         truncate = ($urandom_range(0, 4) == 0);
         for (int c = 0; c < n_chars; c++) begin
            final_char = (c == n_chars - 1);
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               seq_len = 1;
               seq[0]  = 8'($urandom);
            end else if (roll < 45) begin
               seq_len = 1;
               seq[0]  = 8'($urandom_range(0, 127));
            end else begin
               seq_len = (roll < 65) ? 2 : (roll < 80) ? 3 : (roll < 90) ? 4 :
                         (roll < 95) ? 5 : 6;
               if (seq_len == 6)
                  seq[0] = 8'hFC | 8'($urandom_range(0, 3));
               else
                  seq[0] = (8'hFF << (8 - seq_len)) |
                           (8'($urandom) & ((8'd1 << (7 - seq_len)) - 8'd1));
               for (int k = 1; k < seq_len; k++)
                  seq[k] = {2'b10, 6'($urandom)};
            end
            emit_count = seq_len;
            if (final_char && truncate && seq_len > 1)
               emit_count = $urandom_range(1, seq_len - 1);
            for (int k = 0; k < emit_count; k++)
               queue_byte(seq[k], final_char && (k == emit_count - 1));
            random_bytes += emit_count;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      // room for any stray beat still in the pipeline
      repeat (8) @(posedge clock);

      $display("%0d bytes sent, %0d code units checked (%0d cut short)",
               bytes_accepted, units_checked, partial_units);
      $display("%0d cycles of input back-pressure, %0d long receiver hold-offs",
               input_stalls, holds_done);
      if (mismatches == 0 && expected_units.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timeout with %0d code units outstanding", expected_units.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
